FILE: rtl/core/swgs_pkg.sv
package swgs_pkg;

  // Field widths
  localparam int unsigned SCORE_W    = 17;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned DENOM_W    = 24;
  localparam int unsigned RATIO_W    = 16;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned LIMIT_W    = RATIO_W + DENOM_W;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 24;

  // Scores per first-level peak group in the back end
  localparam int unsigned GROUP_LEN = 4;

  // Register reset values
  localparam logic [IDX_W-1:0]   QUERY_INDEX_RST      = 16'd0;
  localparam logic [DENOM_W-1:0] DENOM_RST            = 24'd65536;
  localparam logic [IDX_W-1:0]   EXCLUSION_RADIUS_RST = 16'd100;
  localparam logic [RATIO_W-1:0] REJECT_RATIO_RST     = 16'd19661;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_INDEX      = 8'd0,
    REG_DENOM            = 8'd1,
    REG_EXCLUSION_RADIUS = 8'd2,
    REG_REJECT_RATIO     = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0]   query_index;
    logic [DENOM_W-1:0] denom;
    logic [IDX_W-1:0]   exclusion_radius;
    logic [RATIO_W-1:0] reject_ratio;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] best_index;
    logic [IDX_W-1:0] window_end;
  } res_t;

endpackage

FILE: rtl/core/swgs_fifo.sv
module swgs_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              wr_en, rd_en;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/swgs_front.sv
module swgs_front #(
  parameter int unsigned WINDOW_LEN  = 9,
  parameter int unsigned MAX_ENTRIES = 65536,
  parameter int unsigned SUM_W       = 20,
  parameter int unsigned MID_W       = 173
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  swgs_pkg::cfg_t                    cfg_i,
  input  logic                              push_i,
  input  logic [swgs_pkg::SCORE_W-1:0]      score_i,
  input  logic                              last_i,
  output logic                              full_o,
  output logic                              mid_push_o,
  output logic [MID_W-1:0]                  mid_data_o,
  input  logic                              mid_full_i
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [CNT_W-1:0]                                cnt_q;
  logic [WINDOW_LEN-1:0][swgs_pkg::SCORE_W-1:0]    win_q, win_new;
  logic [WINDOW_LEN-1:0]                           pass_q, pass_new;
  logic [SUM_W-1:0]                                sum_q, sum_new;
  logic [swgs_pkg::LIMIT_W-1:0]                    limit;
  logic [swgs_pkg::LIMIT_W-1:0]                    score_scaled;
  logic [swgs_pkg::IDX_W-1:0]                      idx, query_gap;
  logic                                            accept, active, score_pass, qual;

  assign full_o = mid_full_i;
  assign accept = push_i && !mid_full_i;
  assign active = (cnt_q < CNT_W'(MAX_ENTRIES));
  assign idx    = swgs_pkg::IDX_W'(cnt_q);

  // Threshold test: score * 2^16 >= reject_ratio * denom
  assign limit        = swgs_pkg::LIMIT_W'(cfg_i.reject_ratio)
                      * swgs_pkg::LIMIT_W'(cfg_i.denom);
  assign score_scaled = swgs_pkg::LIMIT_W'({score_i, {swgs_pkg::FRAC_W{1'b0}}});
  assign score_pass   = (score_scaled >= limit);

  // Shift the new score in at the top, oldest drops out at slot 0
  assign win_new  = {score_i, win_q[WINDOW_LEN-1:1]};
  assign pass_new = {score_pass, pass_q[WINDOW_LEN-1:1]};
  assign sum_new  = sum_q + SUM_W'(score_i) - SUM_W'(win_q[0]);

  // Classify the window that ends at this entry
  always_comb begin
    query_gap = (cfg_i.query_index > idx) ? (cfg_i.query_index - idx)
                                          : (idx - cfg_i.query_index);
    qual = active
        && (idx >= swgs_pkg::IDX_W'(WINDOW_LEN - 1))
        && (query_gap >= cfg_i.exclusion_radius)
        && (&pass_new);
  end

  assign mid_push_o = accept;
  assign mid_data_o = {win_new, sum_new, idx, qual, last_i};

  // Hold the window state; clear it at the end of a list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      win_q  <= '0;
      pass_q <= '0;
      sum_q  <= '0;
    end else if (accept) begin
      if (last_i) begin
        cnt_q  <= '0;
        win_q  <= '0;
        pass_q <= '0;
        sum_q  <= '0;
      end else if (active) begin
        cnt_q  <= cnt_q + 1'b1;
        win_q  <= win_new;
        pass_q <= pass_new;
        sum_q  <= sum_new;
      end
    end
  end

endmodule

FILE: rtl/core/swgs_back.sv
module swgs_back #(
  parameter int unsigned WINDOW_LEN = 9,
  parameter int unsigned SUM_W      = 20,
  parameter int unsigned MID_W      = 173
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mid_empty_i,
  input  logic [MID_W-1:0]  mid_data_i,
  output logic              mid_pop_o,
  output logic              res_push_o,
  output swgs_pkg::res_t    res_o,
  input  logic              res_full_i
);

  localparam int unsigned GL   = swgs_pkg::GROUP_LEN;
  localparam int unsigned NG   = (WINDOW_LEN + GL - 1) / GL;
  localparam int unsigned KW   = $clog2(WINDOW_LEN);
  localparam int unsigned SW   = swgs_pkg::SCORE_W;
  localparam int unsigned IW   = swgs_pkg::IDX_W;

  // Unpacked view of the queue head
  logic [WINDOW_LEN-1:0][SW-1:0] m_win;
  logic [SUM_W-1:0]              m_sum;
  logic [IW-1:0]                 m_end;
  logic                          m_qual, m_last;

  assign {m_win, m_sum, m_end, m_qual, m_last} = mid_data_i;

  // Stage registers
  logic                     s1_valid_q;
  logic [NG-1:0][SW-1:0]    g_val_q, g_val_d;
  logic [NG-1:0][KW-1:0]    g_k_q, g_k_d;
  logic [SUM_W-1:0]         s1_sum_q;
  logic [IW-1:0]            s1_end_q;
  logic                     s1_qual_q, s1_last_q;

  // Best window of the current list
  logic [SUM_W-1:0]         best_sum_q;
  logic [IW-1:0]            best_peak_q, best_end_q;
  logic                     any_q;

  logic                     fire, load;
  logic [SW-1:0]            pk_val;
  logic [KW-1:0]            pk_k;
  logic [IW-1:0]            peak_idx;
  logic                     win;

  assign fire      = s1_valid_q && (!s1_last_q || !res_full_i);
  assign load      = !mid_empty_i && (!s1_valid_q || fire);
  assign mid_pop_o = load;

  // First level: peak of each group of scores, lowest slot on ties
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      g_val_d[g] = '0;
      g_k_d[g]   = KW'(g * GL);
      for (int j = 0; j < GL; j++) begin
        if ((g * GL + j) < WINDOW_LEN) begin
          if (m_win[g * GL + j] > g_val_d[g]) begin
            g_val_d[g] = m_win[g * GL + j];
            g_k_d[g]   = KW'(g * GL + j);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (load) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      g_val_q   <= g_val_d;
      g_k_q     <= g_k_d;
      s1_sum_q  <= m_sum;
      s1_end_q  <= m_end;
      s1_qual_q <= m_qual;
      s1_last_q <= m_last;
    end
  end

  // Second level: peak across groups, then judge against the best sum
  always_comb begin
    pk_val = '0;
    pk_k   = '0;
    for (int g = 0; g < NG; g++) begin
      if (g_val_q[g] > pk_val) begin
        pk_val = g_val_q[g];
        pk_k   = g_k_q[g];
      end
    end
    peak_idx = s1_end_q - IW'(WINDOW_LEN - 1) + IW'(pk_k);
    win      = s1_qual_q && (s1_sum_q > best_sum_q);
  end

  // Build the result from this beat's verdict and the running best
  always_comb begin
    res_push_o       = fire && s1_last_q;
    res_o.found      = win || any_q;
    res_o.best_index = win ? peak_idx : (any_q ? best_peak_q : '0);
    res_o.window_end = win ? s1_end_q : (any_q ? best_end_q : '0);
  end

  // Update the best window; drop it after the result of a list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_sum_q  <= '0;
      best_peak_q <= '0;
      best_end_q  <= '0;
      any_q       <= 1'b0;
    end else if (fire) begin
      if (s1_last_q) begin
        best_sum_q  <= '0;
        best_peak_q <= '0;
        best_end_q  <= '0;
        any_q       <= 1'b0;
      end else if (win) begin
        best_sum_q  <= s1_sum_q;
        best_peak_q <= peak_idx;
        best_end_q  <= s1_end_q;
        any_q       <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/score_window_group_select.sv
// Sliding-window group select over a stream of similarity scores.
//
// Input queue side: present score_i/last_i and raise push; a beat is taken at
// an edge where push is high and full is low. Scores belong to entries 0, 1,
// 2, ... of a list; last_i ends it. One beat a cycle is taken while full is low.
// Result queue side: while empty is low, found_o/best_index_o/window_end_o
// show the oldest result; pop takes it. One result per list, on its last beat.
// An accepted last beat passes the front queue, then the first-level peak
// registers, then the peak and best-sum compare into the result queue.
// The front end shifts the window and keeps a running sum; a two-entry queue
// feeds the back end, which finds the window peak in a two-level registered
// search and keeps the best window. A two-entry result queue holds results,
// so a stalled receiver holds results while inputs keep flowing until both
// internal queues fill, then full rises.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Write registers only while the block is idle.
// Reset: registers go to their defaults, both queues empty, list state clear.
module score_window_group_select #(
  parameter int unsigned WINDOW_LEN  = 9,
  parameter int unsigned MAX_ENTRIES = 65536
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [swgs_pkg::SCORE_W-1:0]         score_i,
  input  logic                                 last_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 found_o,
  output logic [swgs_pkg::IDX_W-1:0]           best_index_o,
  output logic [swgs_pkg::IDX_W-1:0]           window_end_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [swgs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [swgs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned SUM_W =
      $clog2(WINDOW_LEN * (2 ** swgs_pkg::SCORE_W - 1) + 1);
  localparam int unsigned MID_W =
      WINDOW_LEN * swgs_pkg::SCORE_W + SUM_W + swgs_pkg::IDX_W + 2;
  localparam int unsigned Q_DEPTH = 2;

  swgs_pkg::cfg_t cfg_q;
  swgs_pkg::res_t res_in, res_out;

  logic             mid_push, mid_full, mid_pop, mid_empty;
  logic [MID_W-1:0] mid_wdata, mid_rdata;
  logic             res_push, res_full;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.query_index      <= swgs_pkg::QUERY_INDEX_RST;
      cfg_q.denom            <= swgs_pkg::DENOM_RST;
      cfg_q.exclusion_radius <= swgs_pkg::EXCLUSION_RADIUS_RST;
      cfg_q.reject_ratio     <= swgs_pkg::REJECT_RATIO_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (swgs_pkg::cfg_reg_e'(cfg_index_i))
        swgs_pkg::REG_QUERY_INDEX: begin
          cfg_q.query_index <= cfg_data_i[swgs_pkg::IDX_W-1:0];
        end
        swgs_pkg::REG_DENOM: begin
          cfg_q.denom <= cfg_data_i[swgs_pkg::DENOM_W-1:0];
        end
        swgs_pkg::REG_EXCLUSION_RADIUS: begin
          cfg_q.exclusion_radius <= cfg_data_i[swgs_pkg::IDX_W-1:0];
        end
        swgs_pkg::REG_REJECT_RATIO: begin
          cfg_q.reject_ratio <= cfg_data_i[swgs_pkg::RATIO_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  swgs_front #(
    .WINDOW_LEN  (WINDOW_LEN),
    .MAX_ENTRIES (MAX_ENTRIES),
    .SUM_W       (SUM_W),
    .MID_W       (MID_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .score_i    (score_i),
    .last_i     (last_i),
    .full_o     (full),
    .mid_push_o (mid_push),
    .mid_data_o (mid_wdata),
    .mid_full_i (mid_full)
  );

  swgs_fifo #(
    .DATA_W (MID_W),
    .DEPTH  (Q_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  swgs_back #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W),
    .MID_W      (MID_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_rdata),
    .mid_pop_o   (mid_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  swgs_fifo #(
    .DATA_W ($bits(swgs_pkg::res_t)),
    .DEPTH  (Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign found_o      = res_out.found;
  assign best_index_o = res_out.best_index;
  assign window_end_o = res_out.window_end;

`ifndef SYNTHESIS
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && res_full))
    else $error("result beat pushed into a full result queue");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !found_o) |-> (best_index_o == '0 && window_end_o == '0))
    else $error("empty result carries nonzero index fields");

  a_peak_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && found_o) |->
      (window_end_o >= swgs_pkg::IDX_W'(WINDOW_LEN - 1) &&
       best_index_o <= window_end_o &&
       best_index_o >= window_end_o - swgs_pkg::IDX_W'(WINDOW_LEN - 1)))
    else $error("peak index lies outside the winning window");
`endif

endmodule

FILE: verif/score_window_group_select_tb.sv
`timescale 1ns / 1ps

module score_window_group_select_tb;

  localparam int unsigned WIN_LEN       = 9;
  localparam int unsigned ENTRY_CAP     = 65536;
  localparam int unsigned ITEM_TARGET   = 900;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // Expected winner of each score list, tracked beat by beat
  class peak_window_board;
    logic [swgs_pkg::IDX_W-1:0]   query_index;
    logic [swgs_pkg::DENOM_W-1:0] denom;
    logic [swgs_pkg::IDX_W-1:0]   exclusion_radius;
    logic [swgs_pkg::RATIO_W-1:0] reject_ratio;
    logic [swgs_pkg::SCORE_W-1:0] recent [WIN_LEN];
    int unsigned                  next_entry;
    logic [20:0]                  top_sum;
    logic [swgs_pkg::IDX_W-1:0]   top_peak;
    logic [swgs_pkg::IDX_W-1:0]   top_end;
    bit                           top_valid;
    swgs_pkg::res_t               winners_due [$];
    int unsigned                  fault_count;

    function void clear_list();
      foreach (recent[k]) recent[k] = '0;
      next_entry = 0;
      top_sum    = '0;
      top_peak   = '0;
      top_end    = '0;
      top_valid  = 1'b0;
    endfunction

    function void power_on();
      query_index      = swgs_pkg::QUERY_INDEX_RST;
      denom            = swgs_pkg::DENOM_RST;
      exclusion_radius = swgs_pkg::EXCLUSION_RADIUS_RST;
      reject_ratio     = swgs_pkg::REJECT_RATIO_RST;
      fault_count      = 0;
      clear_list();
    endfunction

    function void set_register(swgs_pkg::cfg_reg_e idx,
                               logic [swgs_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        swgs_pkg::REG_QUERY_INDEX:      query_index      = data[swgs_pkg::IDX_W-1:0];
        swgs_pkg::REG_DENOM:            denom            = data[swgs_pkg::DENOM_W-1:0];
        swgs_pkg::REG_EXCLUSION_RADIUS: exclusion_radius = data[swgs_pkg::IDX_W-1:0];
        swgs_pkg::REG_REJECT_RATIO:     reject_ratio     = data[swgs_pkg::RATIO_W-1:0];
        default: ;
      endcase
    endfunction

    // Score the window at end_idx; keep it if all pass and its sum beats the best
    function void weigh_window(int unsigned end_idx);
      longint unsigned              limit;
      logic [20:0]                  total;
      logic [swgs_pkg::SCORE_W-1:0] peak;
      int unsigned                  peak_idx;
      limit    = longint'(reject_ratio) * longint'(denom);
      total    = '0;
      peak     = '0;
      peak_idx = 0;
      for (int k = 0; k < WIN_LEN; k++) begin
        if ((longint'(recent[k]) << swgs_pkg::FRAC_W) < limit) return;
        if (recent[k] > peak) begin
          peak     = recent[k];
          peak_idx = end_idx - (WIN_LEN - 1) + k;
        end
        total = total + recent[k];
      end
      if (total > top_sum) begin
        top_sum   = total;
        top_peak  = peak_idx[swgs_pkg::IDX_W-1:0];
        top_end   = end_idx[swgs_pkg::IDX_W-1:0];
        top_valid = 1'b1;
      end
    endfunction

    function void note_score(logic [swgs_pkg::SCORE_W-1:0] score, logic fin);
      int unsigned    idx;
      int unsigned    query_gap;
      swgs_pkg::res_t outcome;
      if (next_entry < ENTRY_CAP) begin
        idx = next_entry;
        for (int k = 0; k < WIN_LEN - 1; k++) recent[k] = recent[k+1];
        recent[WIN_LEN-1] = score;
        query_gap = (query_index > idx) ? (query_index - idx) : (idx - query_index);
        if (idx >= WIN_LEN - 1 && query_gap >= exclusion_radius) weigh_window(idx);
        next_entry = idx + 1;
      end
      if (fin) begin
        outcome.found      = top_valid;
        outcome.best_index = top_valid ? top_peak : '0;
        outcome.window_end = top_valid ? top_end : '0;
        winners_due = {winners_due, outcome};
        clear_list();
      end
    endfunction

    function void check_winner(logic found, logic [swgs_pkg::IDX_W-1:0] best_index,
                               logic [swgs_pkg::IDX_W-1:0] window_end);
      swgs_pkg::res_t want;
      if (winners_due.size() == 0) begin
        $error("unexpected result beat: found=%0d best_index=%0d window_end=%0d",
               found, best_index, window_end);
        fault_count++;
        return;
      end
      want = winners_due.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, found);
        fault_count++;
      end
      if (best_index !== want.best_index) begin
        $error("best_index: expected %0d, got %0d", want.best_index, best_index);
        fault_count++;
      end
      if (window_end !== want.window_end) begin
        $error("window_end: expected %0d, got %0d", want.window_end, window_end);
        fault_count++;
      end
    endfunction

    function int unsigned pending();
      return winners_due.size();
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            push = 1'b0;
  logic                            full;
  logic [swgs_pkg::SCORE_W-1:0]    score_i = '0;
  logic                            last_i = 1'b0;
  logic                            empty;
  logic                            pop = 1'b0;
  logic                            found_o;
  logic [swgs_pkg::IDX_W-1:0]      best_index_o;
  logic [swgs_pkg::IDX_W-1:0]      window_end_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  swgs_pkg::cfg_reg_e              cfg_index_i = swgs_pkg::REG_QUERY_INDEX;
  logic [swgs_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  peak_window_board board;
  bit               send_idle_on = 1'b1;
  bit               recv_idle_on = 1'b1;
  bit               long_hold_req = 1'b0;
  int unsigned      cycle_count = 0;

  // Peak tie in a passing window, then the threshold edge breaks later windows
  logic [swgs_pkg::SCORE_W-1:0] tie_list [11] = '{40000, 65536, 50000, 65536, 32768,
                                                  33000, 60000, 40000, 45000, 32767,
                                                  65536};
  // Zero-sum windows first, then small sums with a zero threshold
  logic [swgs_pkg::SCORE_W-1:0] low_list [12] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 3, 1, 1};

  score_window_group_select #(
    .WINDOW_LEN (WIN_LEN),
    .MAX_ENTRIES(ENTRY_CAP)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .score_i     (score_i),
    .last_i      (last_i),
    .empty       (empty),
    .pop         (pop),
    .found_o     (found_o),
    .best_index_o(best_index_o),
    .window_end_o(window_end_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one score beat after a random gap; hold it until taken
  task automatic send_score(input logic [swgs_pkg::SCORE_W-1:0] score, input logic fin);
    int unsigned gap;
    gap = send_idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    score_i <= score;
    last_i  <= fin;
    do @(posedge clk_i); while (full);
    board.note_score(score, fin);
  endtask

  // Stop offering, wait for every due result, then let the pipeline settle
  task automatic drain();
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers back to back
  task automatic load_settings(input logic [swgs_pkg::CFG_DATA_W-1:0] query,
                               input logic [swgs_pkg::CFG_DATA_W-1:0] norm,
                               input logic [swgs_pkg::CFG_DATA_W-1:0] radius,
                               input logic [swgs_pkg::CFG_DATA_W-1:0] ratio);
    swgs_pkg::cfg_reg_e              order [4];
    logic [swgs_pkg::CFG_DATA_W-1:0] vals [4];
    order = '{swgs_pkg::REG_QUERY_INDEX, swgs_pkg::REG_DENOM,
              swgs_pkg::REG_EXCLUSION_RADIUS, swgs_pkg::REG_REJECT_RATIO};
    vals  = '{query, norm, radius, ratio};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      board.set_register(order[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly passing scores, with edge values and occasional rejects
  function automatic logic [swgs_pkg::SCORE_W-1:0] draw_score(int unsigned pass_floor);
    int unsigned pick;
    pick = $urandom_range(0, 31);
    if (pick == 0) return 17'd65536;
    if (pick == 1) return '0;
    if (pass_floor > 0 && pick == 2) begin
      return swgs_pkg::SCORE_W'($urandom_range(0, pass_floor - 1));
    end
    if (pass_floor > 0 && pass_floor <= 65537 && pick == 3) begin
      return swgs_pkg::SCORE_W'(pass_floor - 1);
    end
    if (pass_floor > 65536) return swgs_pkg::SCORE_W'($urandom_range(0, 65536));
    if (pick == 4) return swgs_pkg::SCORE_W'(pass_floor);
    return swgs_pkg::SCORE_W'($urandom_range(pass_floor, 65536));
  endfunction

  // Result side: pop after a random stall, or the long hold when asked
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = recv_idle_on ? $urandom_range(0, 8) : 0;
      if (long_hold_req) begin
        stall         = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      board.check_winner(found_o, best_index_o, window_end_o);
    end
  end

  initial begin : stimulus
    int unsigned                     random_items;
    int unsigned                     phase;
    int unsigned                     lists;
    int unsigned                     len;
    int unsigned                     pass_floor;
    longint unsigned                 limit;
    logic [swgs_pkg::CFG_DATA_W-1:0] query;
    logic [swgs_pkg::CFG_DATA_W-1:0] norm;
    logic [swgs_pkg::CFG_DATA_W-1:0] radius;
    logic [swgs_pkg::CFG_DATA_W-1:0] ratio;
    board = new;
    board.power_on();
    random_items = 0;
    phase        = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-entry list under reset settings: nothing can qualify
    send_score(17'd65536, 1'b1);

    // Half threshold, no exclusion: tie on the peak, rejects at the edge
    drain();
    load_settings(24'd4, 24'd65536, 24'd0, 24'd32768);
    foreach (tie_list[k]) send_score(tie_list[k], k == 10);

    // Zero denominator passes everything; zero sums must still lose
    drain();
    load_settings(24'd4, 24'd0, 24'd0, 24'd32768);
    foreach (low_list[k]) send_score(low_list[k], k == 11);

    // Random settings, a few lists each
    while (random_items < ITEM_TARGET) begin
      drain();
      case ($urandom_range(0, 5))
        0:       query = 24'd0;
        1:       query = 24'd65535;
        2:       query = swgs_pkg::CFG_DATA_W'($urandom_range(0, 65535));
        default: query = swgs_pkg::CFG_DATA_W'($urandom_range(0, 60));
      endcase
      case ($urandom_range(0, 5))
        0:       radius = 24'd0;
        1:       radius = 24'd65535;
        2:       radius = swgs_pkg::CFG_DATA_W'($urandom_range(0, 65535));
        default: radius = swgs_pkg::CFG_DATA_W'($urandom_range(0, 25));
      endcase
      case ($urandom_range(0, 5))
        0:       norm = 24'd1;
        1:       norm = 24'hFFFFFF;
        2:       norm = swgs_pkg::CFG_DATA_W'($urandom_range(1, 24'hFFFFFF));
        default: norm = swgs_pkg::CFG_DATA_W'($urandom_range(32768, 131072));
      endcase
      case ($urandom_range(0, 5))
        0:       ratio = 24'd0;
        1:       ratio = 24'd65535;
        2:       ratio = swgs_pkg::CFG_DATA_W'($urandom_range(0, 65535));
        default: ratio = swgs_pkg::CFG_DATA_W'($urandom_range(0, 40000));
      endcase
      // Toggle the unused upper data bits of the narrow registers
      query[23:16]  = 8'($urandom_range(0, 255));
      radius[23:16] = 8'($urandom_range(0, 255));
      ratio[23:16]  = 8'($urandom_range(0, 255));
      load_settings(query, norm, radius, ratio);
      limit        = longint'(ratio[15:0]) * longint'(norm);
      pass_floor   = 32'((limit + 65535) >> swgs_pkg::FRAC_W);
      send_idle_on = $urandom_range(0, 3) != 0;
      recv_idle_on = $urandom_range(0, 3) != 0;
      if (phase == 0) begin
        // Back up the result side while short lists keep coming
        long_hold_req = 1'b1;
        send_idle_on  = 1'b0;
        for (int n = 0; n < 16; n++) begin
          len = $urandom_range(1, 3);
          for (int j = 0; j < len; j++) begin
            send_score(draw_score(pass_floor), j == len - 1);
            random_items++;
          end
        end
      end else begin
        lists = $urandom_range(1, 4);
        for (int n = 0; n < lists; n++) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
          for (int j = 0; j < len; j++) begin
            send_score(draw_score(pass_floor), j == len - 1);
            random_items++;
          end
        end
      end
      phase++;
    end

    // Short list with no threshold and no exclusion, starting from entry zero
    drain();
    load_settings(24'd0, 24'd65536, 24'd0, 24'd0);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    for (int j = 0; j < 12; j++) begin
      send_score(swgs_pkg::SCORE_W'($urandom_range(1, 65536)), j == 11);
    end

    drain();
    if (board.fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
